// ===== hw/rtl/i2cmbe_pkg.sv =====
// Shared types, codes and constants of the I2C master bit engine.
`default_nettype none
package i2cmbe_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int COUNT_WIDTH   = 16;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int BIT_IDX_W     = 4;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_DELAY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_TIMEOUT = 1'd1;

  // Register values after reset
  localparam logic [CFG_W-1:0] PHASE_DELAY_RST     = 16'd250;
  localparam logic [CFG_W-1:0] STRETCH_TIMEOUT_RST = 16'd200;

  // Operation codes on the input word
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_WRITE,
    CMD_READ,
    CMD_STOP
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_S_REL, PH_S_HIGH, PH_S_SDA, PH_S_SCL,
    PH_W_DATA, PH_W_HIGH, PH_W_LOW,
    PH_A_SETUP, PH_RA_SETUP, PH_A_HIGH, PH_A_HOLD, PH_A_LOW,
    PH_R_REL, PH_R_HIGH, PH_R_HOLD, PH_R_LOW,
    PH_P_LOW, PH_P_HIGH, PH_P_SDA
  } phase_t;

  // One classified tick as it sits in the queue
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] write_byte;
    logic       send_nack;
    logic       scl_level;
    logic       sda_level;
  } tick_t;

  // Phases that release SCL and wait for it to go high
  function automatic logic is_wait(input phase_t ph);
    is_wait = (ph == PH_S_HIGH) || (ph == PH_W_HIGH) || (ph == PH_A_HIGH) ||
              (ph == PH_R_HIGH) || (ph == PH_P_HIGH);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/i2cmbe_if.sv =====
// Valid/ready channel interfaces for the tick words and the result words.
`default_nettype none
interface i2cmbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] write_byte;
  logic       send_nack;
  logic       scl_level;
  logic       sda_level;

  modport source (output valid, operation, write_byte, send_nack, scl_level, sda_level,
                  input ready);
  modport sink   (input valid, operation, write_byte, send_nack, scl_level, sda_level,
                  output ready);
endinterface

interface i2cmbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_pull_low;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_seen;
  logic       timeout_flag;

  modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res, read_byte,
                  ack_seen, timeout_flag, input ready);
  modport sink   (input valid, scl_pull_low, sda_pull_low, busy_res, done_res, read_byte,
                  ack_seen, timeout_flag, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/i2cmbe_front.sv =====
// Front end: accepts tick words and decodes the operation into a command.
`default_nettype none
module i2cmbe_front (
  i2cmbe_in_if.sink           in_ch,
  output logic                push_valid,
  input  wire logic           push_ready,
  output i2cmbe_pkg::tick_t   push_data
);

  i2cmbe_pkg::cmd_t cmd;

  // Decode the operation; unknown codes carry no command
  always_comb begin
    case (in_ch.operation)
      i2cmbe_pkg::OP_START: cmd = i2cmbe_pkg::CMD_START;
      i2cmbe_pkg::OP_WRITE: cmd = i2cmbe_pkg::CMD_WRITE;
      i2cmbe_pkg::OP_READ:  cmd = i2cmbe_pkg::CMD_READ;
      i2cmbe_pkg::OP_STOP:  cmd = i2cmbe_pkg::CMD_STOP;
      default:              cmd = i2cmbe_pkg::CMD_NONE;
    endcase
  end

  // Pack the classified word for the queue
  always_comb begin
    push_data.cmd        = cmd;
    push_data.write_byte = in_ch.write_byte;
    push_data.send_nack  = in_ch.send_nack;
    push_data.scl_level  = in_ch.scl_level;
    push_data.sda_level  = in_ch.sda_level;
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule
`default_nettype wire

// ===== hw/rtl/i2cmbe_queue.sv =====
// Two-entry queue between the front end and the bit engine.
`default_nettype none
module i2cmbe_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire i2cmbe_pkg::tick_t  push_data,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output i2cmbe_pkg::tick_t       pop_data
);

  i2cmbe_pkg::tick_t                  entry_r [i2cmbe_pkg::QUEUE_DEPTH];
  logic [i2cmbe_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [i2cmbe_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [i2cmbe_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                               do_push, do_pop;

  assign push_ready = (count_r != i2cmbe_pkg::QCNT_W'(i2cmbe_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/i2cmbe_engine.sv =====
// Back end: phase sequencer, line drivers, config registers and result register.
`default_nettype none
module i2cmbe_engine (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [i2cmbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [i2cmbe_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire logic                                tick_valid,
  output logic                                     tick_ready,
  input  wire i2cmbe_pkg::tick_t                   tick,
  i2cmbe_out_if.source                             out_ch
);

  localparam int CW = i2cmbe_pkg::COUNT_WIDTH;
  localparam int BW = i2cmbe_pkg::BIT_IDX_W;

  // Configuration registers
  logic [i2cmbe_pkg::CFG_W-1:0] phase_delay_r, stretch_timeout_r;

  // Engine state
  i2cmbe_pkg::phase_t phase_r, phase_nxt, target;
  logic [CW-1:0]      delay_r, delay_nxt;
  logic [CW-1:0]      stretch_r, stretch_nxt;
  logic [BW-1:0]      bit_idx_r, bit_idx_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [7:0]         rx_r, rx_nxt;
  logic               nack_r, nack_nxt;
  logic               ack_r, ack_nxt;
  logic               tmo_r, tmo_nxt;
  logic               rmode_r, rmode_nxt;
  logic               scl_drv_r, scl_drv_nxt;
  logic               sda_drv_r, sda_drv_nxt;
  logic               go, ok, done;
  logic               step;

  // Result register
  logic               out_valid_r;
  logic               res_scl_r, res_sda_r, res_busy_r, res_done_r, res_ack_r, res_tmo_r;
  logic [7:0]         res_rx_r;

  assign tick_ready = !out_valid_r || out_ch.ready;
  assign step       = tick_valid && tick_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_delay_r     <= i2cmbe_pkg::PHASE_DELAY_RST;
      stretch_timeout_r <= i2cmbe_pkg::STRETCH_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cmbe_pkg::CFG_PHASE_DELAY:     phase_delay_r     <= cfg_wdata;
        i2cmbe_pkg::CFG_STRETCH_TIMEOUT: stretch_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Step the phase sequencer by one tick
  always_comb begin
    phase_nxt   = phase_r;
    delay_nxt   = delay_r;
    stretch_nxt = stretch_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    rx_nxt      = rx_r;
    nack_nxt    = nack_r;
    ack_nxt     = ack_r;
    tmo_nxt     = tmo_r;
    rmode_nxt   = rmode_r;
    scl_drv_nxt = scl_drv_r;
    sda_drv_nxt = sda_drv_r;
    target      = i2cmbe_pkg::PH_IDLE;
    go          = 1'b0;
    ok          = 1'b1;
    done        = 1'b0;

    if (phase_r == i2cmbe_pkg::PH_IDLE) begin
      // Launch a command
      if (tick.cmd != i2cmbe_pkg::CMD_NONE) begin
        tmo_nxt = 1'b0;
        go      = 1'b1;
      end
      case (tick.cmd)
        i2cmbe_pkg::CMD_START: begin
          target = i2cmbe_pkg::PH_S_REL;
        end
        i2cmbe_pkg::CMD_WRITE: begin
          ack_nxt     = 1'b0;
          shift_nxt   = tick.write_byte;
          bit_idx_nxt = '0;
          rmode_nxt   = 1'b0;
          target      = i2cmbe_pkg::PH_W_DATA;
        end
        i2cmbe_pkg::CMD_READ: begin
          nack_nxt    = tick.send_nack;
          shift_nxt   = '0;
          bit_idx_nxt = '0;
          rmode_nxt   = 1'b1;
          target      = i2cmbe_pkg::PH_R_REL;
        end
        i2cmbe_pkg::CMD_STOP: begin
          target = i2cmbe_pkg::PH_P_LOW;
        end
        default: ;
      endcase
    end else if (delay_r > CW'(1)) begin
      // Hold in the phase
      delay_nxt = delay_r - 1'b1;
    end else begin
      delay_nxt = '0;
      // Wait for SCL high (and SDA high in PH_S_HIGH), bounded by the stretch timeout
      if (i2cmbe_pkg::is_wait(phase_r)) begin
        ok = tick.scl_level && ((phase_r != i2cmbe_pkg::PH_S_HIGH) || tick.sda_level);
        if (!ok) begin
          if (({1'b0, stretch_r} + 1'b1) >= (CW + 1)'(stretch_timeout_r)) begin
            tmo_nxt = 1'b1;
            ok      = 1'b1;
          end else begin
            stretch_nxt = stretch_r + 1'b1;
          end
        end
      end
      // Advance to the next phase
      if (ok) begin
        go = 1'b1;
        case (phase_r)
          i2cmbe_pkg::PH_S_REL:  target = i2cmbe_pkg::PH_S_HIGH;
          i2cmbe_pkg::PH_S_HIGH: target = i2cmbe_pkg::PH_S_SDA;
          i2cmbe_pkg::PH_S_SDA:  target = i2cmbe_pkg::PH_S_SCL;
          i2cmbe_pkg::PH_W_DATA: target = i2cmbe_pkg::PH_W_HIGH;
          i2cmbe_pkg::PH_W_HIGH: target = i2cmbe_pkg::PH_W_LOW;
          i2cmbe_pkg::PH_W_LOW: begin
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_idx_nxt = bit_idx_r + 1'b1;
            target      = (bit_idx_nxt >= BW'(i2cmbe_pkg::BITS_PER_BYTE)) ?
                          i2cmbe_pkg::PH_A_SETUP : i2cmbe_pkg::PH_W_DATA;
          end
          i2cmbe_pkg::PH_A_SETUP,
          i2cmbe_pkg::PH_RA_SETUP: target = i2cmbe_pkg::PH_A_HIGH;
          i2cmbe_pkg::PH_A_HIGH: begin
            if (!rmode_r) begin
              ack_nxt = !tick.sda_level;
            end
            target = i2cmbe_pkg::PH_A_HOLD;
          end
          i2cmbe_pkg::PH_A_HOLD: target = i2cmbe_pkg::PH_A_LOW;
          i2cmbe_pkg::PH_R_REL:  target = i2cmbe_pkg::PH_R_HIGH;
          i2cmbe_pkg::PH_R_HIGH: target = i2cmbe_pkg::PH_R_HOLD;
          i2cmbe_pkg::PH_R_HOLD: begin
            shift_nxt = {shift_r[6:0], tick.sda_level};
            target    = i2cmbe_pkg::PH_R_LOW;
          end
          i2cmbe_pkg::PH_R_LOW: begin
            bit_idx_nxt = bit_idx_r + 1'b1;
            if (bit_idx_nxt >= BW'(i2cmbe_pkg::BITS_PER_BYTE)) begin
              rx_nxt = shift_r;
              target = i2cmbe_pkg::PH_RA_SETUP;
            end else begin
              target = i2cmbe_pkg::PH_R_HIGH;
            end
          end
          i2cmbe_pkg::PH_P_LOW:  target = i2cmbe_pkg::PH_P_HIGH;
          i2cmbe_pkg::PH_P_HIGH: target = i2cmbe_pkg::PH_P_SDA;
          default: begin
            // Last phase of a command: finish
            go        = 1'b0;
            phase_nxt = i2cmbe_pkg::PH_IDLE;
            done      = 1'b1;
          end
        endcase
      end
    end

    // Enter the target phase and set its line drive
    if (go) begin
      phase_nxt   = target;
      delay_nxt   = CW'(phase_delay_r);
      stretch_nxt = '0;
      case (target)
        i2cmbe_pkg::PH_S_REL:    sda_drv_nxt = 1'b0;
        i2cmbe_pkg::PH_S_SDA:    sda_drv_nxt = 1'b1;
        i2cmbe_pkg::PH_S_SCL:    scl_drv_nxt = 1'b1;
        i2cmbe_pkg::PH_W_DATA: begin
          scl_drv_nxt = 1'b1;
          sda_drv_nxt = !shift_nxt[7];
        end
        i2cmbe_pkg::PH_A_SETUP:  sda_drv_nxt = 1'b0;
        i2cmbe_pkg::PH_RA_SETUP: sda_drv_nxt = !nack_r;
        i2cmbe_pkg::PH_R_REL: begin
          sda_drv_nxt = 1'b0;
          scl_drv_nxt = 1'b1;
        end
        i2cmbe_pkg::PH_P_LOW: begin
          scl_drv_nxt = 1'b1;
          sda_drv_nxt = 1'b1;
        end
        i2cmbe_pkg::PH_P_SDA:    sda_drv_nxt = 1'b0;
        i2cmbe_pkg::PH_S_HIGH,
        i2cmbe_pkg::PH_W_HIGH,
        i2cmbe_pkg::PH_A_HIGH,
        i2cmbe_pkg::PH_R_HIGH,
        i2cmbe_pkg::PH_P_HIGH:   scl_drv_nxt = 1'b0;
        i2cmbe_pkg::PH_W_LOW,
        i2cmbe_pkg::PH_A_LOW,
        i2cmbe_pkg::PH_R_LOW:    scl_drv_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  // Commit engine state on each consumed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= i2cmbe_pkg::PH_IDLE;
      delay_r   <= '0;
      stretch_r <= '0;
      bit_idx_r <= '0;
      shift_r   <= '0;
      rx_r      <= '0;
      nack_r    <= 1'b0;
      ack_r     <= 1'b0;
      tmo_r     <= 1'b0;
      rmode_r   <= 1'b0;
      scl_drv_r <= 1'b0;
      sda_drv_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      delay_r   <= delay_nxt;
      stretch_r <= stretch_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      rx_r      <= rx_nxt;
      nack_r    <= nack_nxt;
      ack_r     <= ack_nxt;
      tmo_r     <= tmo_nxt;
      rmode_r   <= rmode_nxt;
      scl_drv_r <= scl_drv_nxt;
      sda_drv_r <= sda_drv_nxt;
    end
  end

  // Result valid: set on a step, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture the result word
  always_ff @(posedge clk) begin
    if (step) begin
      res_scl_r  <= scl_drv_nxt;
      res_sda_r  <= sda_drv_nxt;
      res_busy_r <= (phase_nxt != i2cmbe_pkg::PH_IDLE);
      res_done_r <= done;
      res_rx_r   <= rx_nxt;
      res_ack_r  <= ack_nxt;
      res_tmo_r  <= tmo_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.scl_pull_low = res_scl_r;
  assign out_ch.sda_pull_low = res_sda_r;
  assign out_ch.busy_res     = res_busy_r;
  assign out_ch.done_res     = res_done_r;
  assign out_ch.read_byte    = res_rx_r;
  assign out_ch.ack_seen     = res_ack_r;
  assign out_ch.timeout_flag = res_tmo_r;

endmodule
`default_nettype wire

// ===== hw/rtl/i2c_master_bit_engine_unit.sv =====
// I2C master bit engine: tick front end, queue and phase engine.
//
// Usage: every tick word on in_ch carries the sampled SCL and SDA levels
// and optionally a command (start, write byte, read byte, stop). Each tick
// word yields exactly one result word on out_ch with the open-drain
// pull-low enables, busy/done status, the last read byte, the ACK seen on
// the last write and the sticky timeout flag of the current command.
// Commands arriving while busy are ignored.
// Throughput: one tick word per cycle while out_ch accepts results; the phase
// engine steps once per cycle, updating its phase registers on each step.
// Path: an accepted word is registered in the two-entry queue, then the
// engine registers its result word in the result register.
// Stall: when out_ch is held, the engine stops stepping, the queue fills
// and in_ch.ready drops once both queue entries are occupied.
// Config: cfg_we writes phase_delay (index 0) or stretch_timeout (index 1);
// write only while the engine is idle.
// Reset: synchronous, active low; queue and result register empty, both
// lines released, phase_delay 250 and stretch_timeout 200.
`default_nettype none
module i2c_master_bit_engine_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  i2cmbe_in_if.sink                              in_ch,
  i2cmbe_out_if.source                           out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [i2cmbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [i2cmbe_pkg::CFG_W-1:0]      cfg_wdata
);

  logic              push_valid, push_ready;
  i2cmbe_pkg::tick_t push_data;
  logic              q_valid, q_ready;
  i2cmbe_pkg::tick_t q_data;

  i2cmbe_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  i2cmbe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  i2cmbe_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .tick_valid (q_valid),
    .tick_ready (q_ready),
    .tick       (q_data),
    .out_ch     (out_ch)
  );

  // A completing command never reports busy in the same word
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done reported together with busy");

  // Input back-pressure only when the queue holds work
  a_stall_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_valid)
    else $error("input stalled with an empty queue");

  // Engine consumes a word only when the result slot is free or draining
  a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready |-> !out_ch.valid || out_ch.ready)
    else $error("engine stepped into an occupied result slot");

endmodule
`default_nettype wire

// ===== test/i2cmbe_checker.sv =====
`timescale 1ns / 1ps
// Bus status predictor and scoreboard for the I2C master bit engine.
module i2cmbe_checker
  import i2cmbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  i2cmbe_in_if                 in_mon,
  i2cmbe_out_if                out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   words_pending,
  output logic                 engine_idle
);

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy;
    logic       done;
    logic [7:0] read_byte;
    logic       ack_seen;
    logic       timeout_flag;
  } bus_status_t;

  bus_status_t status_due[$];
  bus_status_t want;
  bus_status_t seen;

  // Shadow registers and engine state
  logic [CFG_W-1:0]       delay_len;
  logic [CFG_W-1:0]       stretch_limit;
  phase_t                 phase = PH_IDLE;
  logic [COUNT_WIDTH-1:0] delay_left;
  logic [COUNT_WIDTH-1:0] stretch_tries;
  logic [BIT_IDX_W-1:0]   bit_count;
  logic [7:0]             shifter;
  logic [7:0]             rx_byte;
  logic                   nack_pick;
  logic                   ack_got;
  logic                   timed_out;
  logic                   reading;
  logic                   scl_low;
  logic                   sda_low;
  logic                   done_now;
  logic                   scl_ok;

  assign engine_idle = (phase == PH_IDLE);

  // Enter a phase: reload the delay, clear the stretch count, set the line drives
  task automatic load_phase(input phase_t next);
    phase         = next;
    delay_left    = COUNT_WIDTH'(delay_len);
    stretch_tries = '0;
    case (next)
      PH_S_REL, PH_A_SETUP, PH_P_SDA: sda_low = 1'b0;
      PH_S_SDA: sda_low = 1'b1;
      PH_S_SCL, PH_W_LOW, PH_A_LOW, PH_R_LOW: scl_low = 1'b1;
      PH_S_HIGH, PH_W_HIGH, PH_A_HIGH, PH_R_HIGH, PH_P_HIGH: scl_low = 1'b0;
      PH_W_DATA: begin
        scl_low = 1'b1;
        sda_low = !shifter[7];
      end
      PH_RA_SETUP: sda_low = !nack_pick;
      PH_R_REL: begin
        scl_low = 1'b1;
        sda_low = 1'b0;
      end
      PH_P_LOW: begin
        scl_low = 1'b1;
        sda_low = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      delay_len     = PHASE_DELAY_RST;
      stretch_limit = STRETCH_TIMEOUT_RST;
      phase         = PH_IDLE;
      delay_left    = '0;
      stretch_tries = '0;
      bit_count     = '0;
      shifter       = '0;
      rx_byte       = '0;
      nack_pick     = 1'b0;
      ack_got       = 1'b0;
      timed_out     = 1'b0;
      reading       = 1'b0;
      scl_low       = 1'b0;
      sda_low       = 1'b0;
      status_due.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        if (cfg_index == CFG_PHASE_DELAY) begin
          delay_len = cfg_wdata;
        end else if (cfg_index == CFG_STRETCH_TIMEOUT) begin
          stretch_limit = cfg_wdata;
        end
      end

      // Step the engine once per accepted tick word
      if (in_mon.valid && in_mon.ready) begin
        done_now = 1'b0;
        if (phase == PH_IDLE) begin
          if (in_mon.operation inside {OP_START, OP_WRITE, OP_READ, OP_STOP}) begin
            timed_out = 1'b0;
          end
          case (in_mon.operation)
            OP_START: load_phase(PH_S_REL);
            OP_WRITE: begin
              ack_got   = 1'b0;
              shifter   = in_mon.write_byte;
              bit_count = '0;
              reading   = 1'b0;
              load_phase(PH_W_DATA);
            end
            OP_READ: begin
              nack_pick = in_mon.send_nack;
              shifter   = '0;
              bit_count = '0;
              reading   = 1'b1;
              load_phase(PH_R_REL);
            end
            OP_STOP: load_phase(PH_P_LOW);
            default: ;
          endcase
        end else if (delay_left > 1) begin
          delay_left = delay_left - 1'b1;
        end else begin
          delay_left = '0;
          scl_ok     = 1'b1;
          // Wait for SCL high (and SDA high on start); give up after the limit
          if (phase inside {PH_S_HIGH, PH_W_HIGH, PH_A_HIGH, PH_R_HIGH, PH_P_HIGH}) begin
            scl_ok = in_mon.scl_level && (phase != PH_S_HIGH || in_mon.sda_level);
            if (!scl_ok) begin
              if (int'(stretch_tries) + 1 >= int'(stretch_limit)) begin
                timed_out = 1'b1;
                scl_ok    = 1'b1;
              end else begin
                stretch_tries = stretch_tries + 1'b1;
              end
            end
          end
          // Advance to the next phase
          if (scl_ok) begin
            case (phase)
              PH_S_REL:  load_phase(PH_S_HIGH);
              PH_S_HIGH: load_phase(PH_S_SDA);
              PH_S_SDA:  load_phase(PH_S_SCL);
              PH_W_DATA: load_phase(PH_W_HIGH);
              PH_W_HIGH: load_phase(PH_W_LOW);
              PH_W_LOW: begin
                shifter   = {shifter[6:0], 1'b0};
                bit_count = bit_count + 1'b1;
                if (bit_count >= BIT_IDX_W'(BITS_PER_BYTE)) begin
                  load_phase(PH_A_SETUP);
                end else begin
                  load_phase(PH_W_DATA);
                end
              end
              PH_A_SETUP, PH_RA_SETUP: load_phase(PH_A_HIGH);
              PH_A_HIGH: begin
                if (!reading) begin
                  ack_got = !in_mon.sda_level;
                end
                load_phase(PH_A_HOLD);
              end
              PH_A_HOLD: load_phase(PH_A_LOW);
              PH_R_REL:  load_phase(PH_R_HIGH);
              PH_R_HIGH: load_phase(PH_R_HOLD);
              PH_R_HOLD: begin
                shifter = {shifter[6:0], in_mon.sda_level};
                load_phase(PH_R_LOW);
              end
              PH_R_LOW: begin
                bit_count = bit_count + 1'b1;
                if (bit_count >= BIT_IDX_W'(BITS_PER_BYTE)) begin
                  rx_byte = shifter;
                  load_phase(PH_RA_SETUP);
                end else begin
                  load_phase(PH_R_HIGH);
                end
              end
              PH_P_LOW:  load_phase(PH_P_HIGH);
              PH_P_HIGH: load_phase(PH_P_SDA);
              PH_S_SCL, PH_A_LOW, PH_P_SDA: begin
                phase    = PH_IDLE;
                done_now = 1'b1;
              end
              default: ;
            endcase
          end
        end
        status_due.push_back({scl_low, sda_low, phase != PH_IDLE, done_now, rx_byte,
                              ack_got, timed_out});
      end

      // Compare each accepted status word with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        seen = {out_mon.scl_pull_low, out_mon.sda_pull_low, out_mon.busy_res,
                out_mon.done_res, out_mon.read_byte, out_mon.ack_seen, out_mon.timeout_flag};
        if (status_due.size() == 0) begin
          $error("status word arrived with no prediction waiting");
          fail_count++;
        end else begin
          want = status_due.pop_front();
          check_field("scl_pull_low", int'(want.scl_pull_low), int'(seen.scl_pull_low));
          check_field("sda_pull_low", int'(want.sda_pull_low), int'(seen.sda_pull_low));
          check_field("busy_res", int'(want.busy), int'(seen.busy));
          check_field("done_res", int'(want.done), int'(seen.done));
          check_field("read_byte", int'(want.read_byte), int'(seen.read_byte));
          check_field("ack_seen", int'(want.ack_seen), int'(seen.ack_seen));
          check_field("timeout_flag", int'(want.timeout_flag), int'(seen.timeout_flag));
        end
      end
    end
    words_pending = status_due.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Bench top: clock, reset, tick and register stimulus, result back-pressure and verdict.
module tb;
  import i2cmbe_pkg::*;

  // Operation codes with no command behind them
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  typedef enum logic [1:0] {
    SCL_WOBBLE,
    SCL_HELD_LOW,
    SCL_FREE
  } scl_mode_t;

  logic                 clk   = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   fail_count;
  int                   words_pending;
  logic                 engine_idle;

  // Stimulus knobs; the stall knob and squeeze flags are shared with the receiver process
  int        in_gap_pct;
  int        out_stall_pct;
  int        busy_noise_pct;
  scl_mode_t scl_mode;
  int        scl_low_left;
  int        ticks_sent;
  logic      squeeze_req  = 1'b0;
  logic      squeeze_done = 1'b0;

  i2cmbe_in_if  tick_ch ();
  i2cmbe_out_if status_ch ();

  i2c_master_bit_engine_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (tick_ch),
    .out_ch    (status_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  i2cmbe_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (tick_ch),
    .out_mon       (status_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .engine_idle   (engine_idle)
  );

  always #1 clk = ~clk;

  // Hard stop for a hung run
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Offer one tick word at a falling edge and hold it until accepted
  task automatic send_tick(input logic [2:0] op, input logic [7:0] data, input logic nack);
    int gap;
    gap = pick_gap(in_gap_pct);
    if (gap > 0) begin
      tick_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    case (scl_mode)
      SCL_HELD_LOW: tick_ch.scl_level = 1'b0;
      SCL_FREE:     tick_ch.scl_level = 1'b1;
      default: begin
        // Model a slave that stretches the clock in short bursts
        if (scl_low_left > 0) begin
          scl_low_left--;
          tick_ch.scl_level = 1'b0;
        end else if ($urandom_range(0, 99) < 10) begin
          scl_low_left      = $urandom_range(0, 5);
          tick_ch.scl_level = 1'b0;
        end else begin
          tick_ch.scl_level = 1'b1;
        end
      end
    endcase
    tick_ch.valid      = 1'b1;
    tick_ch.operation  = op;
    tick_ch.write_byte = data;
    tick_ch.send_nack  = nack;
    tick_ch.sda_level  = 1'($urandom);
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    @(negedge clk);
    ticks_sent++;
  endtask

  // Issue a command word, then keep ticking until the engine is idle again
  task automatic issue(input logic [2:0] op, input logic [7:0] data, input logic nack);
    send_tick(op, data, nack);
    while (!engine_idle) begin
      if ($urandom_range(0, 99) < busy_noise_pct) begin
        send_tick(3'($urandom_range(OP_NONE, OP_SPARE_LAST)), 8'($urandom), 1'($urandom));
      end else begin
        send_tick(OP_NONE, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // Write a register once the engine is idle and every status word is in
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    tick_ch.valid = 1'b0;
    while (!engine_idle || words_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly well-formed transfers, some lone or bogus commands
  task automatic random_round(input int tick_budget);
    int stop_at;
    int n_wr;
    int n_rd;
    stop_at = ticks_sent + tick_budget;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 99) < 15) begin
        issue(3'($urandom_range(OP_NONE, OP_SPARE_LAST)), 8'($urandom), 1'($urandom));
      end else begin
        n_wr = $urandom_range(1, 2);
        n_rd = $urandom_range(0, 2);
        issue(OP_START, 8'($urandom), 1'($urandom));
        repeat (n_wr) issue(OP_WRITE, 8'($urandom), 1'($urandom));
        for (int k = 0; k < n_rd; k++) begin
          issue(OP_READ, 8'($urandom), (k == n_rd - 1) ? 1'b1 : 1'($urandom));
        end
        issue(OP_STOP, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // Result side: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left      = 0;
    status_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        stall_left   = 400;
      end else if (stall_left == 0) begin
        stall_left = pick_gap(out_stall_pct);
      end
      if (stall_left > 0) begin
        stall_left--;
        status_ch.ready = 1'b0;
      end else begin
        status_ch.ready = 1'b1;
      end
    end
  end

  // Main stimulus and verdict
  initial begin
    int settle_cycles;
    tick_ch.valid      = 1'b0;
    tick_ch.operation  = OP_NONE;
    tick_ch.write_byte = '0;
    tick_ch.send_nack  = 1'b0;
    tick_ch.scl_level  = 1'b1;
    tick_ch.sda_level  = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = CFG_PHASE_DELAY;
    cfg_wdata          = '0;
    in_gap_pct         = 20;
    out_stall_pct      = 20;
    busy_noise_pct     = 0;
    scl_mode           = SCL_WOBBLE;
    scl_low_left       = 0;
    ticks_sent         = 0;
    settle_cycles      = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Timeout after reset: a start against a stuck SCL runs into the stretch timeout
    set_reg(CFG_PHASE_DELAY, 16'd1);
    scl_mode = SCL_HELD_LOW;
    issue(OP_START, 8'h00, 1'b0);
    scl_mode = SCL_WOBBLE;

    // Zero delay and zero timeout behave as one
    set_reg(CFG_PHASE_DELAY, '0);
    set_reg(CFG_STRETCH_TIMEOUT, '0);
    issue(OP_START, 8'h00, 1'b0);
    issue(OP_WRITE, 8'hFF, 1'b0);
    issue(OP_WRITE, 8'h00, 1'b1);
    scl_mode = SCL_HELD_LOW;
    issue(OP_WRITE, 8'hA5, 1'b0);
    scl_mode = SCL_WOBBLE;
    issue(OP_READ, 8'h00, 1'b1);
    issue(OP_READ, 8'hFF, 1'b0);
    // A write starts from idle; the stop and start offered while it is busy are dropped
    send_tick(OP_WRITE, 8'h3C, 1'b0);
    send_tick(OP_STOP, 8'hC3, 1'b1);
    send_tick(OP_START, 8'h00, 1'b0);
    issue(OP_NONE, 8'h00, 1'b0);
    // Spare codes while idle do nothing
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
      send_tick(3'(op), 8'h5A, 1'b1);
    end
    issue(OP_STOP, 8'h00, 1'b0);

    // Short phases, tight timeout, one long result hold-off
    set_reg(CFG_PHASE_DELAY, 16'd1);
    set_reg(CFG_STRETCH_TIMEOUT, 16'($urandom_range(1, 4)));
    busy_noise_pct = 10;
    in_gap_pct     = 25;
    out_stall_pct  = 25;
    squeeze_req    = 1'b1;
    random_round(60);

    // No idling on either side, widest timeout
    set_reg(CFG_PHASE_DELAY, 16'($urandom_range(2, 3)));
    set_reg(CFG_STRETCH_TIMEOUT, 16'hFFFF);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    random_round(60);

    // Heavy idling, random small settings
    set_reg(CFG_PHASE_DELAY, 16'($urandom_range(0, 2)));
    set_reg(CFG_STRETCH_TIMEOUT, 16'($urandom_range(1, 8)));
    in_gap_pct     = 40;
    out_stall_pct  = 40;
    busy_noise_pct = 15;
    random_round(60);

    // Longer phases, widest timeout: a single stop at full speed
    set_reg(CFG_PHASE_DELAY, 16'd8);
    set_reg(CFG_STRETCH_TIMEOUT, 16'hFFFF);
    in_gap_pct     = 0;
    out_stall_pct  = 0;
    busy_noise_pct = 5;
    scl_mode       = SCL_FREE;
    issue(OP_STOP, 8'h00, 1'b0);

    // Drain the remaining status words
    tick_ch.valid = 1'b0;
    while (words_pending != 0 && settle_cycles < 2000) begin
      @(negedge clk);
      settle_cycles++;
    end
    repeat (4) @(negedge clk);
    if (words_pending != 0) begin
      $error("%0d predicted status words never arrived", words_pending);
    end
    if (fail_count == 0 && words_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/i2cmbe_pkg.sv
hw/rtl/i2cmbe_if.sv
hw/rtl/i2cmbe_front.sv
hw/rtl/i2cmbe_queue.sv
hw/rtl/i2cmbe_engine.sv
hw/rtl/i2c_master_bit_engine_unit.sv
test/i2cmbe_checker.sv
test/tb.sv
